/* design/infix_to_postfix_converter_core_assert.svh */
// ============================================================================
// Assertion macros for the infix to postfix converter
// Shorthand for clocked checks on i_clk, disabled while i_rst_n is low.
// ============================================================================
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH

// The condition must never hold at a clock edge.
`define ITP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/itp_pkg.sv */
// ============================================================================
// itp_pkg
// Shared types, constants and the operator precedence decoder.
// ============================================================================
`timescale 1ns / 1ps

package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // The queue depth must be a power of two so the pointers wrap freely.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;
    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;

    typedef logic [1:0] t_rank;

    localparam t_rank RANK_NONE = 2'd0;
    localparam t_rank RANK_ADD  = 2'd2;
    localparam t_rank RANK_MUL  = 2'd3;

    typedef struct packed {
        logic [7:0] chr;
        t_rank      rank;
        logic       last;
    } t_op_item;

    typedef struct packed {
        logic     valid;
        t_op_item item;
    } t_queue_head;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             flushing;
        logic             ovf_seen;
    } t_back_status;

    typedef enum logic {
        BK_RUN,
        BK_FLUSH
    } t_back_state;

    function automatic t_rank op_rank(input logic [7:0] c);
        t_rank r;
        unique case (c) inside
            CH_MUL, CH_DIV: r = RANK_MUL;
            CH_ADD, CH_SUB: r = RANK_ADD;
            default:        r = RANK_NONE;
        endcase
        return r;
    endfunction

endpackage

/* design/itp_front.sv */
// ============================================================================
// itp_front
// Accepts characters, tags each with its precedence and queues it for the
// back end.
// ============================================================================
`timescale 1ns / 1ps

module itp_front
    import itp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_expr,
    output t_queue_head o_head,
    input  logic        i_deq
);

    t_op_item          r_q_data [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_q_cnt;

    logic              w_full;
    logic              w_accept;
    logic              w_pop;
    t_op_item          w_new_item;

    assign w_full     = (r_q_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;
    assign w_pop      = i_deq && (r_q_cnt != '0);

    always_comb begin
        w_new_item.chr  = i_char_in;
        w_new_item.rank = op_rank(i_char_in);
        w_new_item.last = i_end_of_expr;
    end

    assign o_head.valid = (r_q_cnt != '0);
    assign o_head.item  = r_q_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (w_accept) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_accept && !w_pop) begin
                r_q_cnt <= r_q_cnt + QCNT_W'(1);
            end else if (w_pop && !w_accept) begin
                r_q_cnt <= r_q_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q_data[r_wr_ptr] <= w_new_item;
        end
    end

endmodule

/* design/itp_back.sv */
// ============================================================================
// itp_back
// Operator stack sequencer: emits operands, pops higher or equal precedence
// operators, pushes new ones and flushes the stack at the end of an
// expression, at most one result per cycle into the output register unless it stalls.
// ============================================================================
`timescale 1ns / 1ps

module itp_back
    import itp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_queue_head  i_head,
    output logic         o_deq,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [7:0]   o_char_out,
    output logic         o_last_out,
    output logic         o_stack_overflowed,
    output t_back_status o_status
);

    t_back_state      r_state;
    t_back_state      n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic [7:0]       r_stack [STACK_DEPTH];

    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;
    logic             r_out_ovf;

    logic             w_out_free;
    logic [CNT_W-1:0] w_top_pos;
    logic [IDX_W-1:0] w_top_idx;
    logic [7:0]       w_top_char;
    t_rank            w_top_rank;

    logic             w_emit;
    logic [7:0]       w_emit_char;
    logic             w_emit_last;
    logic             w_emit_ovf;
    logic             w_push;
    logic             w_pop;
    logic             w_ovf_set;
    logic             w_ovf_clr;
    logic             w_go_flush;
    logic             w_flush_done;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_top_pos  = r_cnt - CNT_W'(1);
    assign w_top_idx  = w_top_pos[IDX_W-1:0];
    assign w_top_char = r_stack[w_top_idx];
    assign w_top_rank = op_rank(w_top_char);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_RUN: begin
                if (w_go_flush) begin
                    n_state = BK_FLUSH;
                end
            end
            BK_FLUSH: begin
                if (w_flush_done) begin
                    n_state = BK_RUN;
                end
            end
            default: n_state = BK_RUN;
        endcase
    end

    always_comb begin
        w_emit       = 1'b0;
        w_emit_char  = w_top_char;
        w_emit_last  = 1'b0;
        w_emit_ovf   = 1'b0;
        w_push       = 1'b0;
        w_pop        = 1'b0;
        w_ovf_set    = 1'b0;
        w_ovf_clr    = 1'b0;
        w_go_flush   = 1'b0;
        w_flush_done = 1'b0;
        o_deq        = 1'b0;
        unique case (r_state)
            BK_RUN: begin
                if (i_head.valid) begin
                    if (i_head.item.rank == RANK_NONE) begin
                        if (w_out_free) begin
                            w_emit      = 1'b1;
                            w_emit_char = i_head.item.chr;
                            o_deq       = 1'b1;
                            if (i_head.item.last) begin
                                if (r_cnt == '0) begin
                                    w_emit_last = 1'b1;
                                    w_emit_ovf  = r_ovf;
                                    w_ovf_clr   = 1'b1;
                                end else begin
                                    w_go_flush = 1'b1;
                                end
                            end
                        end
                    end else if ((r_cnt != '0) && (w_top_rank >= i_head.item.rank)) begin
                        // Pop one operator per cycle while the output is free, until the top ranks lower.
                        if (w_out_free) begin
                            w_emit = 1'b1;
                            w_pop  = 1'b1;
                        end
                    end else begin
                        o_deq = 1'b1;
                        if (r_cnt != CNT_W'(STACK_DEPTH)) begin
                            w_push = 1'b1;
                        end else begin
                            w_ovf_set = 1'b1;
                        end
                        if (i_head.item.last) begin
                            w_go_flush = 1'b1;
                        end
                    end
                end
            end
            BK_FLUSH: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    w_pop  = 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        w_emit_last  = 1'b1;
                        w_emit_ovf   = r_ovf;
                        w_ovf_clr    = 1'b1;
                        w_flush_done = 1'b1;
                    end
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_push) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop) begin
                r_cnt <= w_top_pos;
            end
            if (w_ovf_set) begin
                r_ovf <= 1'b1;
            end else if (w_ovf_clr) begin
                r_ovf <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[r_cnt[IDX_W-1:0]] <= i_head.item.chr;
        end
        if (w_emit) begin
            r_out_char <= w_emit_char;
            r_out_last <= w_emit_last;
            r_out_ovf  <= w_emit_ovf;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_char_out         = r_out_char;
    assign o_last_out         = r_out_last;
    assign o_stack_overflowed = r_out_ovf;

    assign o_status.cnt      = r_cnt;
    assign o_status.flushing = (r_state == BK_FLUSH);
    assign o_status.ovf_seen = r_ovf;

endmodule

/* design/infix_to_postfix_converter_core.sv */
// ============================================================================
// infix_to_postfix_converter_core
// Shunting-yard conversion of an infix character stream into postfix form.
// ============================================================================
// Usage: characters arrive on the input channel (i_in_valid, o_in_stall,
// i_char_in, i_end_of_expr), one item per character, with i_end_of_expr set
// on the final character of an expression. Postfix characters leave on the
// output channel (o_out_valid, i_out_stall, o_char_out, o_last_out,
// o_stack_overflowed); o_last_out marks the final character of each postfix
// expression and o_stack_overflowed is only ever set on that item.
// An accepted operand passes through the queue and into the output register.
// An operator first pops each stacked operator of equal or higher rank and
// is then pushed, and the end of an expression pops every operator left on
// the stack. The back-end sequencer emits at most one item per cycle.
// A two-entry queue separates the input side from the sequencer, so input
// keeps flowing while a result waits. When i_out_stall is high the output
// item holds and the sequencer pauses at its next result; pushes still go
// ahead. The input stalls once the queue fills.
// Reset empties the queue and the operator stack and clears the overflow flag.
// ============================================================================
`timescale 1ns / 1ps

`include "infix_to_postfix_converter_core_assert.svh"

module infix_to_postfix_converter_core
    import itp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_expr,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_char_out,
    output logic       o_last_out,
    output logic       o_stack_overflowed
);

    t_queue_head  w_head;
    logic         w_deq;
    t_back_status w_status;

    itp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_in     (i_char_in),
        .i_end_of_expr (i_end_of_expr),
        .o_head        (w_head),
        .i_deq         (w_deq)
    );

    itp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (w_head),
        .o_deq              (w_deq),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_char_out         (o_char_out),
        .o_last_out         (o_last_out),
        .o_stack_overflowed (o_stack_overflowed),
        .o_status           (w_status)
    );

    // The stack never holds more than its depth.
    `ITP_ASSERT_NEVER(a_cnt_range, w_status.cnt > CNT_W'(STACK_DEPTH), "stack count overrun")
    // A flush never runs on an empty stack.
    `ITP_ASSERT_NEVER(a_flush_nonempty, w_status.flushing && (w_status.cnt == '0), "empty flush")
    // Stacked ranks rise strictly, so the stack cannot overflow.
    `ITP_ASSERT_NEVER(a_no_overflow, w_status.ovf_seen, "operator stack overflow")
    // The overflow flag only appears on the final item of an expression.
    `ITP_ASSERT_NEVER(a_ovf_on_last, o_out_valid && o_stack_overflowed && !o_last_out, "stray ovf")
    // Leaving the flush always empties the stack.
    `ITP_ASSERT_NEXT(a_flush_empties, w_status.flushing && !i_out_stall && (w_status.cnt == CNT_W'(1)), w_status.cnt == '0, "flush did not empty stack")

endmodule

/* dv/infix_to_postfix_converter_core_tb.sv */
// ============================================================================
// infix_to_postfix_converter_core_tb
// Sends infix character streams through the converter with random idling on
// both channels. Each postfix character that comes out is checked against a
// shunting-yard model kept inside the bench.
// ============================================================================
`timescale 1ns / 1ps

module infix_to_postfix_converter_core_tb;
    import itp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] chr;
        logic       last;
        logic       ovf;
    } t_postfix_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_char_in = 8'h00;
    logic       i_end_of_expr = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_char_out;
    logic       o_last_out;
    logic       o_stack_overflowed;

    // Model state: operator stack, its fill level and the dropped-push flag.
    logic [7:0]    op_stack [STACK_DEPTH];
    int unsigned   op_count = 0;
    bit            op_dropped = 1'b0;
    t_postfix_char postfix_q [$];

    bit idle_on = 1'b1;
    int chars_sent = 0;
    int mismatches = 0;
    int sink_hold = 0;
    int cycle_count = 0;

    infix_to_postfix_converter_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_char_in          (i_char_in),
        .i_end_of_expr      (i_end_of_expr),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_char_out         (o_char_out),
        .o_last_out         (o_last_out),
        .o_stack_overflowed (o_stack_overflowed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("infix_to_postfix_converter_core verification failed");
            $finish;
        end
    end

    function automatic t_rank prec_of(input logic [7:0] c);
        if (c == CH_MUL || c == CH_DIV) return RANK_MUL;
        if (c == CH_ADD || c == CH_SUB) return RANK_ADD;
        return RANK_NONE;
    endfunction

    function automatic void emit_char(input logic [7:0] c);
        t_postfix_char r;
        r.chr  = c;
        r.last = 1'b0;
        r.ovf  = 1'b0;
        postfix_q.push_back(r);
    endfunction

    // Shunting-yard step for one accepted item; queues the postfix output.
    function automatic void convert_char(input logic [7:0] c, input logic eoe);
        t_rank rk;
        int    n;
        rk = prec_of(c);
        n  = 0;
        if (rk == RANK_NONE) begin
            emit_char(c);
            n++;
        end else begin
            while (op_count > 0 && prec_of(op_stack[op_count-1]) >= rk) begin
                op_count--;
                emit_char(op_stack[op_count]);
                n++;
            end
            if (op_count < STACK_DEPTH) begin
                op_stack[op_count] = c;
                op_count++;
            end else begin
                op_dropped = 1'b1;
            end
        end
        if (eoe) begin
            while (op_count > 0) begin
                op_count--;
                emit_char(op_stack[op_count]);
                n++;
            end
            if (n > 0) begin
                postfix_q[postfix_q.size()-1].last = 1'b1;
                postfix_q[postfix_q.size()-1].ovf  = op_dropped;
            end
            op_dropped = 1'b0;
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eoe);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_char_in     <= c;
        i_end_of_expr <= eoe;
        do @(posedge i_clk); while (o_in_stall);
        convert_char(c, eoe);
        chars_sent++;
    endtask

    function automatic logic [7:0] rand_operand();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (prec_of(c) != RANK_NONE);
        return c;
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 3))
            0: return CH_ADD;
            1: return CH_SUB;
            2: return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    task automatic send_expr(input int n_operands);
        for (int k = 0; k < n_operands; k++) begin
            send_char(rand_operand(), k == n_operands - 1);
            if (k != n_operands - 1) send_char(rand_operator(), 1'b0);
        end
    endtask

    // Output side: random stall bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
        end else if (idle_on && i_rst_n && $urandom_range(0, 5) == 0) begin
            sink_hold = $urandom_range(1, 8);
        end
        i_out_stall <= (sink_hold > 0);
    end

    always @(posedge i_clk) begin
        t_postfix_char want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (postfix_q.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: unexpected item char=%h last=%b ovf=%b",
                             o_char_out, o_last_out, o_stack_overflowed);
                mismatches++;
            end else begin
                want = postfix_q.pop_front();
                if (o_char_out !== want.chr || o_last_out !== want.last ||
                        o_stack_overflowed !== want.ovf) begin
                    if (mismatches < 10)
                        $display("ERROR: expected char=%h last=%b ovf=%b, got char=%h last=%b ovf=%b",
                                 want.chr, want.last, want.ovf,
                                 o_char_out, o_last_out, o_stack_overflowed);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_operands();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    // Equal precedence pops, higher precedence pops, ending on an operator
    // and an expression that starts with operators.
    task automatic test_operators();
        send_char("a", 1'b0); send_char(CH_ADD, 1'b0); send_char("b", 1'b0);
        send_char(CH_SUB, 1'b0); send_char("c", 1'b1);
        send_char("a", 1'b0); send_char(CH_MUL, 1'b0); send_char("b", 1'b0);
        send_char(CH_DIV, 1'b0); send_char("c", 1'b0); send_char(CH_ADD, 1'b0);
        send_char("d", 1'b1);
        send_char("x", 1'b0); send_char(CH_ADD, 1'b0); send_char("y", 1'b0);
        send_char(CH_MUL, 1'b1);
        send_char(CH_SUB, 1'b1);
        send_char(CH_ADD, 1'b0); send_char(CH_MUL, 1'b0); send_char("z", 1'b1);
    endtask

    // Mostly well-formed expressions, with raw noise and broken sequences.
    task automatic test_random_exprs(input int n_items);
        int stop_at;
        int kind;
        int n;
        stop_at = chars_sent + n_items;
        while (chars_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                send_expr($urandom_range(1, 6));
            end else if (kind == 8) begin
                n = $urandom_range(1, 4);
                repeat (n) send_char(8'($urandom_range(0, 255)),
                                     $urandom_range(0, 3) == 0);
            end else begin
                send_char(rand_operand(), 1'b0);
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) send_char(rand_operator(), k == n - 1);
            end
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        repeat (5) send_expr($urandom_range(2, 4));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_operands();
        test_operators();
        test_random_exprs(110);
        test_steady_stream();
        i_in_valid <= 1'b0;
        while (postfix_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && postfix_q.size() == 0) begin
            $display("infix_to_postfix_converter_core verification clean");
        end else begin
            $display("infix_to_postfix_converter_core verification failed");
        end
        $finish;
    end

endmodule

/* infix_to_postfix_converter_core.f */
+incdir+design
design/itp_pkg.sv
design/itp_front.sv
design/itp_back.sv
design/infix_to_postfix_converter_core.sv
dv/infix_to_postfix_converter_core_tb.sv
